@@ design/pch_pkg.sv @@
package pch_pkg;

	// Fixed field widths of the command and response transactions.
	localparam int OPCODE_W    = 2;
	localparam int STAMP_W     = 32;
	localparam int INDEX_W     = 11;
	localparam int CLASS_W     = 3;
	localparam int COUNT_W     = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	// Histogram bins saturate at the largest count the field can show.
	localparam logic [COUNT_W-1:0] BIN_MAX = {COUNT_W{1'b1}};

	// Run tags stored with every histogram entry. Tag zero marks a wiped entry.
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

	typedef enum logic [OPCODE_W-1:0] {
		OP_START     = 2'd0,
		OP_EDGE      = 2'd1,
		OP_READ_BIN  = 2'd2,
		OP_READ_MEAS = 2'd3
	} opcode_t;

	typedef enum logic [CLASS_W-1:0] {
		CLS_NONE   = 3'd0,
		CLS_FIRST  = 3'd1,
		CLS_SHORT  = 3'd2,
		CLS_LONG   = 3'd3,
		CLS_WINDOW = 3'd4
	} class_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_EXPECTED  = 1'b0,
		REG_TOLERANCE = 1'b1
	} cfg_reg_t;

	// One histogram memory word.
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [COUNT_W-1:0] count;
	} bin_entry_t;

	// One response transaction as held in the output queue.
	typedef struct packed {
		logic [STAMP_W-1:0] period;
		logic [CLASS_W-1:0] edge_class;
		logic [COUNT_W-1:0] short_count;
		logic [COUNT_W-1:0] long_count;
		logic [COUNT_W-1:0] stored_count;
		logic               run_done;
		logic [STAMP_W-1:0] read_data;
	} result_t;

endpackage

@@ design/pch_if.sv @@
// Command channel: one start, edge capture or read per transaction.
interface pch_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [pch_pkg::OPCODE_W-1:0]  opcode;
	logic [pch_pkg::STAMP_W-1:0]   timestamp;
	logic [pch_pkg::INDEX_W-1:0]   index;

	modport source(output valid, opcode, timestamp, index, input ready);
	modport sink(input valid, opcode, timestamp, index, output ready);
endinterface

// Response channel: one result per command transaction.
interface pch_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pch_pkg::STAMP_W-1:0]   period;
	logic [pch_pkg::CLASS_W-1:0]   edge_class;
	logic [pch_pkg::COUNT_W-1:0]   short_count;
	logic [pch_pkg::COUNT_W-1:0]   long_count;
	logic [pch_pkg::COUNT_W-1:0]   stored_count;
	logic                          run_done;
	logic [pch_pkg::STAMP_W-1:0]   read_data;

	modport source(output valid, period, edge_class, short_count, long_count, stored_count,
		run_done, read_data, input ready);
	modport sink(input valid, period, edge_class, short_count, long_count, stored_count,
		run_done, read_data, output ready);
endinterface

@@ design/pch_ram.sv @@
module pch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one registered read per cycle; a read of the address being
	// written returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/period_capture_histogram_top.sv @@
// Period capture histogram. Each edge transaction carries a counter timestamp; the block
// measures the wrapping period from the previous edge, sorts it into too short, too long or
// in window, counts window periods in a histogram bin indexed by the period and records every
// period in a measurement store until RUN_LENGTH periods are held. The block takes one command
// transaction per cycle while cmd.ready is high, registers it in a second stage and then
// presents the result from a three-entry output queue that keeps commands flowing while the
// response side stalls. The histogram lives in a BIN_COUNT-deep memory that is read in the
// acceptance cycle and written back in the following cycle, with forwarding between
// consecutive edges that hit the same bin. Entries carry a run tag so a start command takes
// effect at once; after reset, and after every 255th start when the tag wraps, a clearing pass
// wipes the histogram memory and holds cmd.ready low. The window bounds are formed when a
// register is written, so commands may follow a configuration write in the next cycle.
module period_capture_histogram_top #(
	parameter int RUN_LENGTH = 1024,
	parameter int BIN_COUNT  = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	pch_cmd_if.sink                          cmd,
	pch_rsp_if.source                        rsp,
	input  logic                             cfg_we,
	input  logic [pch_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pch_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import pch_pkg::*;

	localparam int CW         = $clog2(RUN_LENGTH + 1);
	localparam int AW         = (RUN_LENGTH > 1) ? $clog2(RUN_LENGTH) : 1;
	localparam int BW         = $clog2(BIN_COUNT);
	localparam int FIFO_DEPTH = 3;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int OCC_W      = PTR_W + 1;

	localparam logic [STAMP_W-1:0] RUN_LEN_W   = STAMP_W'(RUN_LENGTH);
	localparam logic [STAMP_W-1:0] BIN_COUNT_W = STAMP_W'(BIN_COUNT);
	localparam logic [CW-1:0]      RUN_FULL    = CW'(RUN_LENGTH);
	localparam logic [BW-1:0]      BIN_LAST    = BW'(BIN_COUNT - 1);
	localparam logic [PTR_W-1:0]   PTR_LAST    = PTR_W'(FIFO_DEPTH - 1);

	// Lower window bound, saturating at zero.
	function automatic logic [STAMP_W-1:0] win_lo(input logic [STAMP_W-1:0] center,
		input logic [STAMP_W-1:0] half);
		win_lo = (center >= half) ? (center - half) : '0;
	endfunction

	// Upper window bound, saturating at the counter's all-ones value.
	function automatic logic [STAMP_W-1:0] win_hi(input logic [STAMP_W-1:0] center,
		input logic [STAMP_W-1:0] half);
		logic [STAMP_W:0] sum;
		sum = {1'b0, center} + {1'b0, half};
		win_hi = sum[STAMP_W] ? {STAMP_W{1'b1}} : sum[STAMP_W-1:0];
	endfunction

	// Configuration and precomputed window bounds.
	logic [STAMP_W-1:0] expected_q;
	logic [STAMP_W-1:0] tolerance_q;
	logic [STAMP_W-1:0] lo_q;
	logic [STAMP_W-1:0] hi_q;

	// Run state.
	logic [STAMP_W-1:0] last_q;
	logic               awaiting_q;
	logic [CW-1:0]      short_q;
	logic [CW-1:0]      long_q;
	logic [CW-1:0]      rec_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               clr_busy_q;
	logic [BW-1:0]      clr_addr_q;

	// Acceptance stage signals.
	opcode_t            op;
	logic               accept;
	logic [STAMP_W-1:0] per_raw;
	logic [STAMP_W-1:0] idx_ext;
	logic               run_full;
	logic               edge_live;
	logic               meas;
	class_t             cls;
	logic [STAMP_W-1:0] last_nx;
	logic               awaiting_nx;
	logic [CW-1:0]      short_nx;
	logic [CW-1:0]      long_nx;
	logic [CW-1:0]      rec_nx;
	logic [EPOCH_W-1:0] epoch_nx;
	logic               start_clear;
	logic [STAMP_W-1:0] short_w;
	logic [STAMP_W-1:0] long_w;
	logic [STAMP_W-1:0] rec_w;
	logic [BW-1:0]      bin_raddr;

	// Histogram memory port signals.
	logic               bin_we;
	logic [BW-1:0]      bin_waddr;
	bin_entry_t         bin_wdata;
	bin_entry_t         bin_rdata;
	logic [STAMP_W-1:0] store_rdata;

	// Second stage.
	logic               valid_s1;
	opcode_t            op_s1;
	logic [STAMP_W-1:0] period_s1;
	class_t             class_s1;
	logic [COUNT_W-1:0] short_s1;
	logic [COUNT_W-1:0] long_s1;
	logic [COUNT_W-1:0] rec_s1;
	logic               done_s1;
	logic [BW-1:0]      bin_addr_s1;
	logic [EPOCH_W-1:0] epoch_s1;
	logic               bin_ok_s1;
	logic               meas_ok_s1;
	logic               fwd_s1;
	bin_entry_t         wr_entry_q;
	bin_entry_t         entry_s1;
	logic               hit_s1;
	logic [COUNT_W-1:0] cur_cnt_s1;
	bin_entry_t         upd_entry_s1;
	logic [STAMP_W-1:0] read_data_s1;
	result_t            result_s1;

	// Output queue.
	result_t            fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W-1:0]   cnt_q;
	logic [OCC_W-1:0]   occupancy;
	logic               pop;
	result_t            head;

	// Register writes; each write also refreshes both window bounds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q  <= '0;
			tolerance_q <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EXPECTED: begin
					expected_q <= cfg_data;
					lo_q       <= win_lo(cfg_data, tolerance_q);
					hi_q       <= win_hi(cfg_data, tolerance_q);
				end
				REG_TOLERANCE: begin
					tolerance_q <= cfg_data;
					lo_q        <= win_lo(expected_q, cfg_data);
					hi_q        <= win_hi(expected_q, cfg_data);
				end
			endcase
		end
	end

	assign op        = opcode_t'(cmd.opcode);
	assign accept    = cmd.valid && cmd.ready;
	assign per_raw   = cmd.timestamp - last_q;
	assign idx_ext   = STAMP_W'(cmd.index);
	assign run_full  = (rec_q == RUN_FULL);
	assign edge_live = (op == OP_EDGE) && !run_full;
	assign meas      = edge_live && !awaiting_q;

	// Classify the measured period against the window and the bin range.
	always_comb begin
		if (meas) begin
			priority if (per_raw < lo_q) begin
				cls = CLS_SHORT;
			end else if ((per_raw > hi_q) || (per_raw >= BIN_COUNT_W)) begin
				cls = CLS_LONG;
			end else begin
				cls = CLS_WINDOW;
			end
		end else if (edge_live) begin
			cls = CLS_FIRST;
		end else begin
			cls = CLS_NONE;
		end
	end

	// Next run state for the command at the input.
	always_comb begin
		last_nx     = last_q;
		awaiting_nx = awaiting_q;
		short_nx    = short_q;
		long_nx     = long_q;
		rec_nx      = rec_q;
		epoch_nx    = epoch_q;
		start_clear = 1'b0;
		unique case (op)
			OP_START: begin
				awaiting_nx = 1'b1;
				short_nx    = '0;
				long_nx     = '0;
				rec_nx      = '0;
				if (epoch_q == EPOCH_LAST) begin
					epoch_nx    = EPOCH_FIRST;
					start_clear = 1'b1;
				end else begin
					epoch_nx = epoch_q + EPOCH_W'(1);
				end
			end
			OP_EDGE: begin
				if (edge_live) begin
					last_nx     = cmd.timestamp;
					awaiting_nx = 1'b0;
				end
				if (meas) begin
					rec_nx = rec_q + CW'(1);
				end
				if (cls == CLS_SHORT) begin
					short_nx = short_q + CW'(1);
				end
				if (cls == CLS_LONG) begin
					long_nx = long_q + CW'(1);
				end
			end
			OP_READ_BIN, OP_READ_MEAS: begin
			end
		endcase
	end

	assign short_w   = STAMP_W'(short_nx);
	assign long_w    = STAMP_W'(long_nx);
	assign rec_w     = STAMP_W'(rec_nx);
	assign bin_raddr = (op == OP_EDGE) ? per_raw[BW-1:0] : idx_ext[BW-1:0];

	// Run state and the histogram clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			awaiting_q <= 1'b1;
			short_q    <= '0;
			long_q     <= '0;
			rec_q      <= '0;
			epoch_q    <= EPOCH_FIRST;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (accept) begin
				last_q     <= last_nx;
				awaiting_q <= awaiting_nx;
				short_q    <= short_nx;
				long_q     <= long_nx;
				rec_q      <= rec_nx;
				epoch_q    <= epoch_nx;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + BW'(1);
				if (clr_addr_q == BIN_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end else if (accept && start_clear) begin
				clr_busy_q <= 1'b1;
				clr_addr_q <= '0;
			end
		end
	end

	// Measurement store: written in order at the fill count, read by slot.
	pch_ram #(
		.WIDTH(STAMP_W),
		.DEPTH(RUN_LENGTH)
	) u_store (
		.clk  (clk),
		.we   (accept && meas),
		.waddr(rec_q[AW-1:0]),
		.wdata(per_raw),
		.raddr(idx_ext[AW-1:0]),
		.rdata(store_rdata)
	);

	// Histogram: the clearing pass owns the write port while it runs.
	assign bin_we    = clr_busy_q || (valid_s1 && (class_s1 == CLS_WINDOW));
	assign bin_waddr = clr_busy_q ? clr_addr_q : bin_addr_s1;
	assign bin_wdata = clr_busy_q ? '0 : upd_entry_s1;

	pch_ram #(
		.WIDTH($bits(bin_entry_t)),
		.DEPTH(BIN_COUNT)
	) u_bins (
		.clk  (clk),
		.we   (bin_we),
		.waddr(bin_waddr),
		.wdata(bin_wdata),
		.raddr(bin_raddr),
		.rdata(bin_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Second stage payload; the forward flag marks a read that races the write-back.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			period_s1   <= meas ? per_raw : '0;
			class_s1    <= cls;
			short_s1    <= short_w[COUNT_W-1:0];
			long_s1     <= long_w[COUNT_W-1:0];
			rec_s1      <= rec_w[COUNT_W-1:0];
			done_s1     <= (rec_nx == RUN_FULL);
			bin_addr_s1 <= bin_raddr;
			epoch_s1    <= epoch_nx;
			bin_ok_s1   <= (idx_ext < BIN_COUNT_W);
			meas_ok_s1  <= (idx_ext < RUN_LEN_W) && (idx_ext < STAMP_W'(rec_q));
			fwd_s1      <= bin_we && (bin_waddr == bin_raddr);
		end
		if (bin_we) begin
			wr_entry_q <= bin_wdata;
		end
	end

	// Bin read-modify-write; an entry from an older run counts as empty.
	assign entry_s1   = fwd_s1 ? wr_entry_q : bin_rdata;
	assign hit_s1     = (entry_s1.epoch == epoch_s1);
	assign cur_cnt_s1 = hit_s1 ? entry_s1.count : '0;

	always_comb begin
		upd_entry_s1.epoch = epoch_s1;
		upd_entry_s1.count = (cur_cnt_s1 == BIN_MAX) ? cur_cnt_s1 : cur_cnt_s1 + COUNT_W'(1);
	end

	// Read data for the two read commands.
	always_comb begin
		unique case (op_s1)
			OP_READ_BIN:  read_data_s1 = bin_ok_s1 ? STAMP_W'(cur_cnt_s1) : '0;
			OP_READ_MEAS: read_data_s1 = meas_ok_s1 ? store_rdata : '0;
			OP_START, OP_EDGE: read_data_s1 = '0;
		endcase
	end

	always_comb begin
		result_s1.period       = period_s1;
		result_s1.edge_class   = class_s1;
		result_s1.short_count  = short_s1;
		result_s1.long_count   = long_s1;
		result_s1.stored_count = rec_s1;
		result_s1.run_done     = done_s1;
		result_s1.read_data    = read_data_s1;
	end

	// Output queue; commands are taken only while room is left for those in flight.
	assign pop       = rsp.valid && rsp.ready;
	assign occupancy = OCC_W'(cnt_q) + OCC_W'(valid_s1);
	assign cmd.ready = !clr_busy_q && (occupancy <= OCC_W'(FIFO_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + PTR_W'(valid_s1) - PTR_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fifo_q[wr_ptr_q] <= result_s1;
		end
	end

	assign head             = fifo_q[rd_ptr_q];
	assign rsp.valid        = (cnt_q != '0);
	assign rsp.period       = head.period;
	assign rsp.edge_class   = head.edge_class;
	assign rsp.short_count  = head.short_count;
	assign rsp.long_count   = head.long_count;
	assign rsp.stored_count = head.stored_count;
	assign rsp.run_done     = head.run_done;
	assign rsp.read_data    = head.read_data;

endmodule

@@ design/pch_checker.sv @@
module pch_checker #(
	parameter int BIN_COUNT = 2048
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [pch_pkg::STAMP_W-1:0]     period,
	input logic [pch_pkg::CLASS_W-1:0]     edge_class,
	input logic [pch_pkg::STAMP_W-1:0]     read_data
);

	import pch_pkg::*;

	// A first edge only primes the timestamp and measures nothing.
	a_first_no_period: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (edge_class == CLS_FIRST) |-> (period == '0))
		else $error("first edge reported a nonzero period");

	// Starts, reads and ignored edges report no period.
	a_none_no_period: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (edge_class == CLS_NONE) |-> (period == '0))
		else $error("period reported without a measurement");

	// Edge captures never return read data.
	a_edge_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (edge_class != CLS_NONE) |-> (read_data == '0))
		else $error("edge capture returned read data");

	// A period counted in the histogram always has a bin.
	a_window_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (edge_class == CLS_WINDOW) |-> (period < STAMP_W'(BIN_COUNT)))
		else $error("window period beyond the last bin");

	// A stalled response holds its transaction.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(period) && $stable(edge_class)
			&& $stable(read_data))
		else $error("response changed while stalled");

endmodule

bind period_capture_histogram_top pch_checker #(
	.BIN_COUNT(BIN_COUNT)
) u_pch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.period    (rsp.period),
	.edge_class(rsp.edge_class),
	.read_data (rsp.read_data)
);
